>>> rtl/cmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmf_pkg
// Types and constants shared by the checksummed message framer modules.
// ----------------------------------------------------------------------------
package cmf_pkg;

  // Item kinds on the input channel
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_ORDER   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_BUF_CAP     = 2'd2;

  // Register reset values
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'd98;
  localparam logic [15:0] BUF_CAP_RST     = 16'd128;

  // Header plus trailer bytes around the payload
  localparam logic [16:0] FRAME_OVERHEAD = 17'd8;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] buffer_capacity;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] pay_len;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
    logic       frame_done;
  } res_t;

endpackage

>>> rtl/checksummed_message_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_message_framer
// Builds sync-headed binary frames with an 8-bit Fletcher trailer as a byte
// stream, from start items and payload byte items.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Contents
//  in_      in   tvalid/tready      tuser = action, tdata = header and payload
//  out_     out  tvalid/tready      tdata = frame byte, tuser = status/last,
//                                   tlast = frame end
//  cfg_     in   cfg_we             cfg_index selects register, cfg_wdata value
//
// One beat leaves per cycle while out_tready is high. An item produces one beat
// (error or plain payload byte), three (final payload byte plus checksum), six
// (frame header) or eight (zero-length frame), and it holds the input register
// until its last beat is issued. Single-beat items stream at one per cycle
// without stalls. Reset clears the frame state and the sums and loads the
// register defaults. A stall on out_tready holds the output beat, freezes the
// sequencer and, once the input register is full, drops in_tready.
//
module checksummed_message_framer (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // msg_class[7:0], msg_id[15:8],
                                  // pay_len[31:16], data_byte[39:32]
  input  logic        in_tuser,   // action[0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic [2:0]  out_tuser,  // status[1:0], last[2]
  output logic        out_tlast,  // frame_done
  // configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cmf_pkg::cfg_t  cfg_r;
  cmf_pkg::item_t item_r;
  logic           item_valid_r;
  cmf_pkg::res_t  res;
  cmf_pkg::res_t  res_r;
  logic           out_valid_r;
  logic           out_load;
  logic           item_done;
  logic           in_take;

  // The output register loads whenever it is empty or being drained
  assign out_load  = !out_valid_r || out_tready;
  // Free the input register on the final beat of its item
  assign in_tready = !item_valid_r || item_done;
  assign in_take   = in_tvalid && in_tready;

  // Configuration registers; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first      <= cmf_pkg::SYNC_FIRST_RST;
      cfg_r.sync_second     <= cmf_pkg::SYNC_SECOND_RST;
      cfg_r.buffer_capacity <= cmf_pkg::BUF_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cmf_pkg::REG_SYNC_FIRST:  cfg_r.sync_first      <= cfg_wdata[7:0];
        cmf_pkg::REG_SYNC_SECOND: cfg_r.sync_second     <= cfg_wdata[7:0];
        cmf_pkg::REG_BUF_CAP:     cfg_r.buffer_capacity <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Input register: hold the item until its last beat is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action    <= in_tuser;
      item_r.msg_class <= in_tdata[7:0];
      item_r.msg_id    <= in_tdata[15:8];
      item_r.pay_len   <= in_tdata[31:16];
      item_r.data_byte <= in_tdata[39:32];
    end
  end

  cmf_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid_r),
    .item       (item_r),
    .adv        (out_load),
    .res        (res),
    .item_done  (item_done)
  );

  // Output register: advance on load, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && item_valid_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.out_byte;
  assign out_tuser  = {res_r.last, res_r.status};
  assign out_tlast  = res_r.frame_done;

endmodule

>>> rtl/cmf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmf_seq
// Frame sequencer: expands one held item into its result bytes, one per
// advance, and keeps the Fletcher sums and the frame bookkeeping.
// ----------------------------------------------------------------------------
module cmf_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  cmf_pkg::cfg_t  cfg,
  input  logic           item_valid,
  input  cmf_pkg::item_t item,
  input  logic           adv,
  output cmf_pkg::res_t  res,
  output logic           item_done
);

  typedef enum logic [1:0] {
    K_ERR_ORDER,
    K_ERR_BIG,
    K_START,
    K_PAYLOAD
  } kind_t;

  typedef enum logic [3:0] {
    B_ZERO,
    B_SYNC1,
    B_SYNC2,
    B_CLASS,
    B_ID,
    B_LEN_LO,
    B_LEN_HI,
    B_DATA,
    B_SUM_A,
    B_SUM_B
  } bsel_t;

  logic [2:0]  step_r, step_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        frame_open_r, frame_open_nxt;

  kind_t       kind;
  bsel_t       bsel;
  logic [2:0]  last_step;
  logic        is_last;
  logic        emit;
  logic        fold;
  logic [7:0]  byte_val;
  logic [7:0]  fold_a;

  // Kind stays stable across the item: frame state only moves on its last step
  always_comb begin
    kind      = K_ERR_ORDER;
    last_step = 3'd0;
    if (item.action == cmf_pkg::ACT_START) begin
      if (frame_open_r) begin
        kind = K_ERR_ORDER;
      end else if (({1'b0, item.pay_len} + cmf_pkg::FRAME_OVERHEAD) >
                   {1'b0, cfg.buffer_capacity}) begin
        kind = K_ERR_BIG;
      end else begin
        kind      = K_START;
        last_step = (item.pay_len == 16'd0) ? 3'd7 : 3'd5;
      end
    end else begin
      if (!frame_open_r) begin
        kind = K_ERR_ORDER;
      end else begin
        kind      = K_PAYLOAD;
        last_step = (bytes_left_r == 16'd1) ? 3'd2 : 3'd0;
      end
    end
  end

  always_comb begin
    bsel = B_ZERO;
    case (kind)
      K_START: begin
        case (step_r)
          3'd0:    bsel = B_SYNC1;
          3'd1:    bsel = B_SYNC2;
          3'd2:    bsel = B_CLASS;
          3'd3:    bsel = B_ID;
          3'd4:    bsel = B_LEN_LO;
          3'd5:    bsel = B_LEN_HI;
          3'd6:    bsel = B_SUM_A;
          3'd7:    bsel = B_SUM_B;
          default: bsel = B_ZERO;
        endcase
      end
      K_PAYLOAD: begin
        case (step_r)
          3'd0:    bsel = B_DATA;
          3'd1:    bsel = B_SUM_A;
          3'd2:    bsel = B_SUM_B;
          default: bsel = B_ZERO;
        endcase
      end
      default: bsel = B_ZERO;
    endcase
  end

  always_comb begin
    byte_val = 8'd0;
    fold     = 1'b0;
    case (bsel)
      B_SYNC1:  byte_val = cfg.sync_first;
      B_SYNC2:  byte_val = cfg.sync_second;
      B_CLASS:  begin byte_val = item.msg_class;      fold = 1'b1; end
      B_ID:     begin byte_val = item.msg_id;         fold = 1'b1; end
      B_LEN_LO: begin byte_val = item.pay_len[7:0];   fold = 1'b1; end
      B_LEN_HI: begin byte_val = item.pay_len[15:8];  fold = 1'b1; end
      B_DATA:   begin byte_val = item.data_byte;      fold = 1'b1; end
      B_SUM_A:  byte_val = sum_a_r;
      B_SUM_B:  byte_val = sum_b_r;
      default:  byte_val = 8'd0;
    endcase
  end

  assign emit      = item_valid && adv;
  assign is_last   = (step_r == last_step);
  assign item_done = emit && is_last;
  assign fold_a    = sum_a_r + byte_val;

  always_comb begin
    res.out_byte   = byte_val;
    res.last       = is_last;
    res.frame_done = (bsel == B_SUM_B);
    case (kind)
      K_ERR_BIG:   res.status = cmf_pkg::ST_TOO_BIG;
      K_ERR_ORDER: res.status = cmf_pkg::ST_ORDER;
      default:     res.status = cmf_pkg::ST_OK;
    endcase
  end

  always_comb begin
    step_nxt       = step_r;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    bytes_left_nxt = bytes_left_r;
    frame_open_nxt = frame_open_r;
    if (emit) begin
      step_nxt = is_last ? 3'd0 : step_r + 3'd1;
      // Clear the sums on the first sync byte, fold the summed bytes
      if (kind == K_START && step_r == 3'd0) begin
        sum_a_nxt = 8'd0;
        sum_b_nxt = 8'd0;
      end else if (fold) begin
        sum_a_nxt = fold_a;
        sum_b_nxt = sum_b_r + fold_a;
      end
      if (is_last) begin
        case (kind)
          K_START: begin
            frame_open_nxt = (item.pay_len != 16'd0);
            bytes_left_nxt = item.pay_len;
          end
          K_PAYLOAD: begin
            bytes_left_nxt = bytes_left_r - 16'd1;
            frame_open_nxt = (bytes_left_r != 16'd1);
          end
          default: begin
            bytes_left_nxt = bytes_left_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= 3'd0;
      sum_a_r      <= 8'd0;
      sum_b_r      <= 8'd0;
      bytes_left_r <= 16'd0;
      frame_open_r <= 1'b0;
    end else begin
      step_r       <= step_nxt;
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
      bytes_left_r <= bytes_left_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for checksummed_message_framer. A directed table covers
// the header and trailer extremes and the ordering and capacity errors. Random
// frame traffic then runs under several register settings, with random gaps
// and one long output hold-off. Every output beat is compared with a frame
// encoder kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;

  // Register index past the three real ones; the block ignores writes to it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int IDLE_LIMIT    = 2000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES = 24;    // quiet time before a register write
  localparam int LONG_HOLD     = 300;   // length of the output hold-off
  localparam int DIR_ROWS      = 17;

  // One row of the directed table. A typed row carries its expected error
  // status; every other row goes through the frame encoder.
  typedef struct packed {
    cmf_pkg::item_t itm;
    logic           typed;
    logic [1:0]     err;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // Side info that travels with the beat on the input bus
  logic        drv_typed;
  logic [1:0]  drv_err;

  // Encoder copy of the block: registers and frame state
  logic [7:0]  reg_sync1 = cmf_pkg::SYNC_FIRST_RST;
  logic [7:0]  reg_sync2 = cmf_pkg::SYNC_SECOND_RST;
  logic [15:0] reg_cap   = cmf_pkg::BUF_CAP_RST;
  logic [7:0]  fl_a      = 8'h00;
  logic [7:0]  fl_b      = 8'h00;
  logic [15:0] remaining = 16'h0000;
  logic        in_frame  = 1'b0;

  cmf_pkg::res_t due_beats[$];   // frame beats predicted but not yet seen
  int   fail_count = 0;
  int   beat_count = 0;
  int   idle_cycles = 0;
  bit   no_gaps  = 1'b0;
  bit   hold_req = 1'b0;

  row_t dir_tab [DIR_ROWS] = '{
    // payload byte with no frame open
    '{'{cmf_pkg::ACT_PAYLOAD, 8'h3C, 8'hC3, 16'h1234, 8'hA5}, 1'b1, cmf_pkg::ST_ORDER},
    // zero-length frames straight after reset, all-zero and all-ones header
    '{'{cmf_pkg::ACT_START,   8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, cmf_pkg::ST_OK},
    '{'{cmf_pkg::ACT_START,   8'hFF, 8'hFF, 16'h0000, 8'hFF}, 1'b0, cmf_pkg::ST_OK},
    // one byte over the default capacity, and the largest length
    '{'{cmf_pkg::ACT_START,   8'h06, 8'h01, 16'd121,  8'h00}, 1'b1, cmf_pkg::ST_TOO_BIG},
    '{'{cmf_pkg::ACT_START,   8'h12, 8'h34, 16'hFFFF, 8'h00}, 1'b1, cmf_pkg::ST_TOO_BIG},
    // three-byte frame with a start thrown in while it is open
    '{'{cmf_pkg::ACT_START,   8'h0A, 8'h0B, 16'd3,    8'h00}, 1'b0, cmf_pkg::ST_OK},
    '{'{cmf_pkg::ACT_START,   8'h01, 8'h02, 16'd0,    8'h00}, 1'b1, cmf_pkg::ST_ORDER},
    '{'{cmf_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, cmf_pkg::ST_OK},
    '{'{cmf_pkg::ACT_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF}, 1'b0, cmf_pkg::ST_OK},
    '{'{cmf_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h80}, 1'b0, cmf_pkg::ST_OK},
    // stray byte after the frame closed
    '{'{cmf_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h7F}, 1'b1, cmf_pkg::ST_ORDER},
    // single-byte frame
    '{'{cmf_pkg::ACT_START,   8'hFF, 8'h00, 16'd1,    8'h00}, 1'b0, cmf_pkg::ST_OK},
    '{'{cmf_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFF}, 1'b0, cmf_pkg::ST_OK},
    // length with only the high byte set
    '{'{cmf_pkg::ACT_START,   8'h00, 8'hFF, 16'h0100, 8'h00}, 1'b1, cmf_pkg::ST_TOO_BIG},
    // two-byte frame
    '{'{cmf_pkg::ACT_START,   8'h80, 8'h01, 16'd2,    8'h00}, 1'b0, cmf_pkg::ST_OK},
    '{'{cmf_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h01}, 1'b0, cmf_pkg::ST_OK},
    '{'{cmf_pkg::ACT_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFE}, 1'b0, cmf_pkg::ST_OK}
  };

  checksummed_message_framer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // msg_class[7:0], msg_id[15:8],
                              // pay_len[31:16], data_byte[39:32]
    .in_tuser   (in_tuser),   // action[0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // out_byte[7:0]
    .out_tuser  (out_tuser),  // status[1:0], last[2]
    .out_tlast  (out_tlast),  // frame_done
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Frame encoder
  // --------------------------------------------------------------------------

  function automatic void emit_beat(logic [7:0] b, logic [1:0] st, logic lst, logic done);
    cmf_pkg::res_t r;
    r.out_byte   = b;
    r.status     = st;
    r.last       = lst;
    r.frame_done = done;
    due_beats.push_back(r);
  endfunction

  // Fold a byte into the Fletcher pair, then queue it as a frame byte
  function automatic void emit_summed(logic [7:0] b, logic lst);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
    emit_beat(b, cmf_pkg::ST_OK, lst, 1'b0);
  endfunction

  // Append both checksum bytes and close the frame
  function automatic void close_frame();
    emit_beat(fl_a, cmf_pkg::ST_OK, 1'b0, 1'b0);
    emit_beat(fl_b, cmf_pkg::ST_OK, 1'b1, 1'b1);
    in_frame  = 1'b0;
    remaining = 16'h0000;
  endfunction

  function automatic void encode_item(cmf_pkg::item_t it);
    if (it.action == cmf_pkg::ACT_START) begin
      if (in_frame) begin
        emit_beat(8'h00, cmf_pkg::ST_ORDER, 1'b1, 1'b0);
      end else if ({1'b0, it.pay_len} + cmf_pkg::FRAME_OVERHEAD > {1'b0, reg_cap}) begin
        emit_beat(8'h00, cmf_pkg::ST_TOO_BIG, 1'b1, 1'b0);
      end else begin
        fl_a = 8'h00;
        fl_b = 8'h00;
        emit_beat(reg_sync1, cmf_pkg::ST_OK, 1'b0, 1'b0);
        emit_beat(reg_sync2, cmf_pkg::ST_OK, 1'b0, 1'b0);
        emit_summed(it.msg_class, 1'b0);
        emit_summed(it.msg_id, 1'b0);
        emit_summed(it.pay_len[7:0], 1'b0);
        // the header ends the item unless the trailer follows at once
        emit_summed(it.pay_len[15:8], it.pay_len != 16'h0000);
        if (it.pay_len == 16'h0000) begin
          close_frame();
        end else begin
          remaining = it.pay_len;
          in_frame  = 1'b1;
        end
      end
    end else begin
      if (!in_frame) begin
        emit_beat(8'h00, cmf_pkg::ST_ORDER, 1'b1, 1'b0);
      end else begin
        remaining = remaining - 16'd1;
        emit_summed(it.data_byte, remaining != 16'h0000);
        if (remaining == 16'h0000) close_frame();
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Beat monitor: check the output first, then predict the accepted input.
  // An output beat can never belong to an item accepted at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cmf_pkg::res_t got;
    cmf_pkg::res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tuser[1:0], out_tuser[2], out_tlast};
        if (due_beats.size() == 0) begin
          if (fail_count < 10)
            $display("beat %0d: unexpected byte %02h status %0d last %0b done %0b",
                     beat_count, got.out_byte, got.status, got.last, got.frame_done);
          fail_count++;
        end else begin
          want = due_beats.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"beat %0d: expected byte %02h status %0d last %0b done %0b, ",
                        "got byte %02h status %0d last %0b done %0b"},
                       beat_count, want.out_byte, want.status, want.last,
                       want.frame_done, got.out_byte, got.status, got.last,
                       got.frame_done);
            fail_count++;
          end
        end
        beat_count++;
      end
      if (in_tvalid && in_tready) begin
        if (drv_typed)
          emit_beat(8'h00, drv_err, 1'b1, 1'b0);
        else
          encode_item({in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[31:16],
                       in_tdata[39:32]});
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // All fields random; fields the action does not use stay random too
  function automatic cmf_pkg::item_t rand_item(logic act);
    cmf_pkg::item_t it;
    it.action    = act;
    it.msg_class = 8'($urandom);
    it.msg_id    = 8'($urandom);
    it.pay_len   = 16'($urandom);
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_item(cmf_pkg::item_t it, logic typed, logic [1:0] err);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {it.data_byte, it.pay_len, it.msg_id, it.msg_class};
    drv_typed <= typed;
    drv_err   <= err;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, drain every predicted beat, then give the block time to go idle
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back, optionally poking the unused index
  task automatic program_regs(logic [7:0] s1, logic [7:0] s2, logic [15:0] cap, bit poke);
    cfg_we    <= 1'b1;
    cfg_index <= cmf_pkg::REG_SYNC_FIRST;
    cfg_wdata <= {8'($urandom), s1};
    @(posedge clk);
    cfg_index <= cmf_pkg::REG_SYNC_SECOND;
    cfg_wdata <= {8'($urandom), s2};
    @(posedge clk);
    cfg_index <= cmf_pkg::REG_BUF_CAP;
    cfg_wdata <= cap;
    @(posedge clk);
    if (poke) begin
      cfg_index <= REG_UNUSED;
      cfg_wdata <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    reg_sync1 = s1;
    reg_sync2 = s2;
    reg_cap   = cap;
    @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; the rest is stray bytes,
  // oversized starts, starts inside an open frame and abandoned frames.
  task automatic run_traffic(int n_items);
    int             sent;
    int             max_ok;
    int             top;
    int             len;
    int             r;
    int             k;
    cmf_pkg::item_t it;
    sent   = 0;
    max_ok = int'(reg_cap) - 8;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(rand_item(cmf_pkg::ACT_PAYLOAD), 1'b0, cmf_pkg::ST_OK);
        sent++;
      end else if (r < 16 || max_ok < 0) begin
        // oversized start; with a capacity below eight every start is one
        it = rand_item(cmf_pkg::ACT_START);
        if (max_ok >= 0)
          it.pay_len = 16'($urandom_range(max_ok + 1, 65535));
        send_item(it, 1'b0, cmf_pkg::ST_OK);
        sent++;
      end else begin
        r   = $urandom_range(0, 99);
        top = (r < 70) ? 6 : (r < 90) ? 24 : 60;
        if (top > max_ok) top = max_ok;
        // now and then hit the capacity limit exactly
        len = ($urandom_range(0, 9) == 0) ? top : $urandom_range(0, top);
        it = rand_item(cmf_pkg::ACT_START);
        it.pay_len = 16'(len);
        send_item(it, 1'b0, cmf_pkg::ST_OK);
        sent++;
        for (k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 3) break;
          if (r < 7) begin
            send_item(rand_item(cmf_pkg::ACT_START), 1'b0, cmf_pkg::ST_OK);
            sent++;
          end
          send_item(rand_item(cmf_pkg::ACT_PAYLOAD), 1'b0, cmf_pkg::ST_OK);
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready stretches broken by random stalls; on request, one long
  // hold-off while the sender keeps offering, so the block backs up.
  // --------------------------------------------------------------------------
  initial begin
    int run;
    int gap;
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        run = $urandom_range(1, 12);
        out_tready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = cmf_pkg::ACT_START;
    drv_typed = 1'b0;
    drv_err   = cmf_pkg::ST_OK;
    cfg_we    = 1'b0;
    cfg_index = cmf_pkg::REG_SYNC_FIRST;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset settings
    foreach (dir_tab[i]) send_item(dir_tab[i].itm, dir_tab[i].typed, dir_tab[i].err);
    settle_idle();

    // Reset settings again, opening with the long output hold-off
    hold_req = 1'b1;
    run_traffic(60);
    settle_idle();

    // Only zero-length frames fit; run back to back with no gaps
    program_regs(8'h00, 8'hFF, 16'd8, 1'b0);
    no_gaps = 1'b1;
    run_traffic(30);
    settle_idle();
    no_gaps = 1'b0;

    // Zero capacity: every start is too big
    program_regs(8'hFF, 8'h00, 16'd0, 1'b1);
    run_traffic(15);
    settle_idle();

    // Largest capacity
    program_regs(8'($urandom), 8'($urandom), 16'hFFFF, 1'b0);
    run_traffic(60);
    settle_idle();

    // Tight capacity, so the limit is hit often
    program_regs(8'($urandom), 8'($urandom), 16'd16, 1'b1);
    run_traffic(40);
    settle_idle();

    program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(8, 80)), 1'b0);
    run_traffic(45);
    settle_idle();

    if (fail_count == 0 && due_beats.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
